// ===== rtl/core/perc_pkg.sv =====
// ============================================================================
// Perceptron learning unit package
// Shared constants, codes and width helpers for the perceptron datapath.
// ============================================================================
package perc_pkg;

    // Default sizing of the weight store.
    localparam int MAX_INPUTS_DEF  = 64;
    localparam int WEIGHT_BITS_DEF = 16;

    // Fixed field widths of the item and result beats.
    localparam int INPUT_W  = 64;
    localparam int SUM_BITS = 23;

    // Configuration port.
    localparam int ACTIVE_W = 7;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;

    // Register index, taken from paddr[2].
    localparam logic REG_ACTIVE_INPUTS = 1'b0;

    typedef enum logic {
        OP_TRAIN    = 1'b0,
        OP_CLASSIFY = 1'b1
    } opcode_t;

    // Width of the internal sum: room for every weight plus the bias,
    // and never narrower than the reported sum field.
    function automatic int acc_width(input int max_inputs, input int weight_bits);
        int w;
        w = weight_bits + $clog2(max_inputs + 1) + 1;
        if (w < SUM_BITS) begin
            w = SUM_BITS;
        end
        return w;
    endfunction

endpackage

// ===== rtl/core/perc_dot.sv =====
// ============================================================================
// Perceptron dot product
// Signs each active weight by its bipolar input and sums them with the bias
// through a balanced adder tree.
// ============================================================================
module perc_dot
    import perc_pkg::*;
#(
    parameter int MAX_INPUTS  = MAX_INPUTS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
    parameter int ACC_W       = acc_width(MAX_INPUTS, WEIGHT_BITS)
) (
    input  logic [MAX_INPUTS-1:0][WEIGHT_BITS-1:0] weights,
    input  logic [WEIGHT_BITS-1:0]                 bias,
    input  logic [MAX_INPUTS-1:0]                  input_bits,
    input  logic [MAX_INPUTS-1:0]                  lane_en,
    output logic signed [ACC_W-1:0]                sum
);

    localparam int LEAVES = 2 ** $clog2(MAX_INPUTS + 1);
    localparam int NODES  = 2 * LEAVES - 1;

    // Heap layout: node k has children 2k+1 and 2k+2, leaves at the end.
    logic signed [ACC_W-1:0] node [NODES];

    for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
        if (j < MAX_INPUTS) begin : g_lane
            logic [WEIGHT_BITS-1:0] term;
            always_comb begin
                if (!lane_en[j]) begin
                    term = '0;
                end else if (input_bits[j]) begin
                    term = weights[j];
                end else begin
                    term = -weights[j];
                end
            end
            assign node[LEAVES-1+j] = {{(ACC_W-WEIGHT_BITS){term[WEIGHT_BITS-1]}}, term};
        end else if (j == MAX_INPUTS) begin : g_bias
            assign node[LEAVES-1+j] = {{(ACC_W-WEIGHT_BITS){bias[WEIGHT_BITS-1]}}, bias};
        end else begin : g_pad
            assign node[LEAVES-1+j] = '0;
        end
    end

    for (genvar k = 0; k < LEAVES - 1; k++) begin : g_add
        assign node[k] = node[2*k+1] + node[2*k+2];
    end

    assign sum = node[0];

endmodule

// ===== rtl/core/perceptron_learning_unit.sv =====
// ============================================================================
// Perceptron learning unit
// Bipolar perceptron with per-input weights and a bias. Classifies each
// example and, in train mode, applies the perceptron rule on an error.
// ============================================================================
//
//  Channel   Ports                                    Direction  Beat
//  --------  ---------------------------------------  ---------  ------------------
//  example   s_valid s_ready s_opcode s_input_bits    in         one example
//            s_expected_class
//  result    m_valid m_ready m_predicted_class        out        one result/example
//            m_error_flag m_weighted_sum
//  config    psel penable pwrite paddr pwdata prdata  in/out     active_inputs reg
//            pready
//
// An example beat lands in the input register; from there the adder tree
// forms the weighted sum, and at the edge that hands the example on the
// result register is loaded and the weights are updated. While results are accepted
// the block takes one example every cycle, since each sum sees the weights that the
// previous example left. The example rate is set by the combinational path from the
// weight registers through the adder tree and back into the weights.
// Reset (aresetn, synchronous) clears all weights and the bias, sets
// active_inputs to 64 and empties both stages. A stalled result holds the result
// register; the input register accepts one more beat only if empty, then holds it.
//
module perceptron_learning_unit
    import perc_pkg::*;
#(
    parameter int MAX_INPUTS  = MAX_INPUTS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_opcode,
    input  logic [INPUT_W-1:0]         s_input_bits,
    input  logic                       s_expected_class,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_predicted_class,
    output logic                       m_error_flag,
    output logic signed [SUM_BITS-1:0] m_weighted_sum,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    localparam int ACC_W = acc_width(MAX_INPUTS, WEIGHT_BITS);

    // Saturation limits, symmetric around zero.
    localparam logic [WEIGHT_BITS-1:0] W_POS_LIM = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic [WEIGHT_BITS-1:0] W_NEG_LIM = {1'b1, {(WEIGHT_BITS-2){1'b0}}, 1'b1};
    localparam logic [WEIGHT_BITS-1:0] W_ONE     = WEIGHT_BITS'(1);

    // ------------------------------------------------------------------
    // Configuration register. The lane enable mask is derived at write
    // time so the datapath sees a plain register.
    // ------------------------------------------------------------------
    logic [ACTIVE_W-1:0]   active_reg, active_next;
    logic [MAX_INPUTS-1:0] lane_en_reg, lane_en_next;
    logic                  cfg_write;
    logic [ACTIVE_W-1:0]   active_clamped;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_INPUTS);
    assign prdata    = {{(DATA_W-ACTIVE_W){1'b0}}, active_reg};

    always_comb begin
        active_next    = cfg_write ? pwdata[ACTIVE_W-1:0] : active_reg;
        // A count above the store depth uses every lane.
        active_clamped = (active_next > ACTIVE_W'(MAX_INPUTS)) ?
                         ACTIVE_W'(MAX_INPUTS) : active_next;
        for (int i = 0; i < MAX_INPUTS; i++) begin
            lane_en_next[i] = ACTIVE_W'(i) < active_clamped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= ACTIVE_RESET;
            lane_en_reg <= '1;
        end else begin
            active_reg  <= active_next;
            lane_en_reg <= lane_en_next;
        end
    end

    // ------------------------------------------------------------------
    // Input register. It refills in the same cycle it hands its example
    // to the result stage.
    // ------------------------------------------------------------------
    logic                  in_valid_reg;
    opcode_t               in_opcode_reg;
    logic [MAX_INPUTS-1:0] in_bits_reg;
    logic                  in_good_reg;
    logic                  advance;

    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_opcode_reg <= opcode_t'(s_opcode);
            in_bits_reg   <= s_input_bits[MAX_INPUTS-1:0];
            in_good_reg   <= s_expected_class;
        end
    end

    // ------------------------------------------------------------------
    // Weighted sum and classification.
    // ------------------------------------------------------------------
    logic [MAX_INPUTS-1:0][WEIGHT_BITS-1:0] weight_reg, weight_next;
    logic [WEIGHT_BITS-1:0]                 bias_reg, bias_next;
    logic signed [ACC_W-1:0]                sum;
    logic                                   sum_pos, sum_neg;
    logic                                   predicted;
    logic                                   error;
    logic                                   do_update;

    perc_dot #(
        .MAX_INPUTS  (MAX_INPUTS),
        .WEIGHT_BITS (WEIGHT_BITS),
        .ACC_W       (ACC_W)
    ) u_dot (
        .weights    (weight_reg),
        .bias       (bias_reg),
        .input_bits (in_bits_reg),
        .lane_en    (lane_en_reg),
        .sum        (sum)
    );

    assign sum_neg   = sum[ACC_W-1];
    assign sum_pos   = !sum_neg && (sum != '0);
    assign predicted = sum_pos;

    // Training counts a zero sum as a miss; classification compares the
    // thresholded prediction with the expected class.
    always_comb begin
        if (in_opcode_reg == OP_TRAIN) begin
            error = !((sum_pos && in_good_reg) || (sum_neg && !in_good_reg));
        end else begin
            error = predicted != in_good_reg;
        end
    end

    assign do_update = advance && (in_opcode_reg == OP_TRAIN) && error;

    // ------------------------------------------------------------------
    // Perceptron rule: each active weight steps toward expected*input,
    // the bias toward expected, all saturating at the limits.
    // ------------------------------------------------------------------
    always_comb begin
        weight_next = weight_reg;
        bias_next   = bias_reg;
        if (do_update) begin
            for (int i = 0; i < MAX_INPUTS; i++) begin
                if (lane_en_reg[i]) begin
                    if (in_bits_reg[i] == in_good_reg) begin
                        if (weight_reg[i] != W_POS_LIM) begin
                            weight_next[i] = weight_reg[i] + W_ONE;
                        end
                    end else begin
                        if (weight_reg[i] != W_NEG_LIM) begin
                            weight_next[i] = weight_reg[i] - W_ONE;
                        end
                    end
                end
            end
            if (in_good_reg) begin
                if (bias_reg != W_POS_LIM) begin
                    bias_next = bias_reg + W_ONE;
                end
            end else begin
                if (bias_reg != W_NEG_LIM) begin
                    bias_next = bias_reg - W_ONE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= '0;
            bias_reg   <= '0;
        end else begin
            weight_reg <= weight_next;
            bias_reg   <= bias_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic                       m_valid_reg;
    logic                       m_pred_reg;
    logic                       m_error_reg;
    logic signed [SUM_BITS-1:0] m_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_pred_reg  <= predicted;
            m_error_reg <= error;
            m_sum_reg   <= sum[SUM_BITS-1:0];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_predicted_class = m_pred_reg;
    assign m_error_flag      = m_error_reg;
    assign m_weighted_sum    = m_sum_reg;

endmodule
